[sv/xtea_pkg.sv]
`timescale 1ns / 1ps

package xtea_pkg;

    // Block and key geometry
    localparam int WORD_W     = 32;
    localparam int KEY_WORDS  = 4;
    localparam int KEY_SEL_W  = $clog2(KEY_WORDS);
    localparam int CYCLES     = 32;
    localparam int NUM_STEPS  = 2 * CYCLES;
    localparam int SUM_SHIFT  = 11;
    localparam int MIX_SHL    = 4;
    localparam int MIX_SHR    = 5;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [KEY_SEL_W-1:0] key_sel_t;
    typedef word_t                key_array_t [KEY_WORDS];

    localparam word_t DELTA = 32'h9e37_79b9;

    typedef enum logic
    {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } action_t;

    // One block in flight: x is updated from y at each step, then the halves swap
    typedef struct packed
    {
        action_t action;
        word_t   x;
        word_t   y;
    } stage_data_t;

    // Running sum used by a given half-round step
    function automatic word_t step_sum(input int step, input logic dec);
        int    round;
        word_t mult;
        round = step >> 1;
        if (!dec)
        begin
            mult = ((step & 1) == 0) ? word_t'(round) : word_t'(round + 1);
        end
        else
        begin
            mult = ((step & 1) == 0) ? word_t'(CYCLES - round) : word_t'(CYCLES - round - 1);
        end
        return word_t'(DELTA * mult);
    endfunction

    // Key word picked by a given half-round step
    function automatic key_sel_t step_key_sel(input int step, input logic dec);
        word_t s;
        logic  low_sel;
        s = step_sum(step, dec);
        // Encrypt even and decrypt odd steps use the low sum bits
        low_sel = (((step & 1) == 0) && !dec) || (((step & 1) != 0) && dec);
        return low_sel ? s[KEY_SEL_W-1:0] : s[SUM_SHIFT +: KEY_SEL_W];
    endfunction

endpackage

[sv/xtea_block_cipher.sv]
`timescale 1ns / 1ps

// XTEA engine, 64-bit block and 128-bit key. Each of the 32 round pairs is
// split into two half-round register stages, so a block passes through 64
// register stages on its way to the output. One block per cycle is taken and
// delivered while the output is not stalled, encrypt and decrypt freely mixed.
// Every stage keeps its word when the next one stalls and fills its bubbles,
// so a stalled output only blocks the input once all 64 stages hold a block.
// The key is four words written through cfg_write/cfg_index/cfg_data (reset
// to zero); change it only while no block is in flight.
module xtea_block_cipher
    import xtea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [KEY_SEL_W-1:0] cfg_index,
    input  word_t                cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  word_t                first_word,
    input  word_t                second_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output word_t                out_first_word,
    output word_t                out_second_word
);

    key_array_t  key;
    logic        pipe_valid [NUM_STEPS+1];
    logic        pipe_stall [NUM_STEPS+1];
    stage_data_t pipe_data  [NUM_STEPS+1];
    stage_data_t entry_data;
    stage_data_t last_data;

    xtea_key_bank u_key_bank
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // Decrypt starts by updating the second half, so swap halves on entry
    always_comb
    begin
        entry_data.action = action_t'(action);
        entry_data.x      = (action_t'(action) == ACT_DECRYPT) ? second_word : first_word;
        entry_data.y      = (action_t'(action) == ACT_DECRYPT) ? first_word : second_word;
    end

    assign pipe_data[0]          = entry_data;
    assign pipe_valid[0]         = in_valid;
    assign in_stall              = pipe_stall[0];
    assign pipe_stall[NUM_STEPS] = out_stall;

    // Half-round stages, each with its own fixed sum and key word
    for (genvar g = 0; g < NUM_STEPS; g++)
    begin : g_step
        localparam word_t    ENC_SUM = step_sum(g, 1'b0);
        localparam word_t    DEC_SUM = step_sum(g, 1'b1);
        localparam key_sel_t ENC_SEL = step_key_sel(g, 1'b0);
        localparam key_sel_t DEC_SEL = step_key_sel(g, 1'b1);

        word_t enc_term;
        word_t dec_term;

        assign enc_term = ENC_SUM + key[ENC_SEL];
        assign dec_term = DEC_SUM + key[DEC_SEL];

        xtea_round u_round
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .enc_term   (enc_term),
            .dec_term   (dec_term),
            .up_valid   (pipe_valid[g]),
            .up_stall   (pipe_stall[g]),
            .up_data    (pipe_data[g]),
            .down_valid (pipe_valid[g+1]),
            .down_stall (pipe_stall[g+1]),
            .down_data  (pipe_data[g+1])
        );
    end

    // Undo the entry swap for decrypted blocks
    assign last_data       = pipe_data[NUM_STEPS];
    assign out_valid       = pipe_valid[NUM_STEPS];
    assign out_first_word  = (last_data.action == ACT_DECRYPT) ? last_data.y : last_data.x;
    assign out_second_word = (last_data.action == ACT_DECRYPT) ? last_data.x : last_data.y;

endmodule

[sv/xtea_key_bank.sv]
`timescale 1ns / 1ps

module xtea_key_bank
    import xtea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [KEY_SEL_W-1:0] cfg_index,
    input  word_t                cfg_data,
    output key_array_t           key
);

    key_array_t key_reg;

    // Capture key words from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    assign key = key_reg;

endmodule

[sv/xtea_round.sv]
`timescale 1ns / 1ps

module xtea_round
    import xtea_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  word_t       enc_term,
    input  word_t       dec_term,
    input  logic        up_valid,
    output logic        up_stall,
    input  stage_data_t up_data,
    output logic        down_valid,
    input  logic        down_stall,
    output stage_data_t down_data
);

    logic        valid_reg;
    stage_data_t data_reg;
    stage_data_t data_next;
    logic        advance;
    word_t       mix_val;
    word_t       round_val;

    // Half round: mix the untouched half, fold in sum plus key, add or subtract
    always_comb
    begin
        mix_val   = word_t'((up_data.y << MIX_SHL) ^ (up_data.y >> MIX_SHR)) + up_data.y;
        round_val = mix_val ^ ((up_data.action == ACT_DECRYPT) ? dec_term : enc_term);
        data_next.action = up_data.action;
        data_next.x      = up_data.y;
        data_next.y      = (up_data.action == ACT_DECRYPT) ? (up_data.x - round_val)
                                                           : (up_data.x + round_val);
    end

    // Advance when empty or when the next stage takes this word
    assign advance  = !valid_reg || !down_stall;
    assign up_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    // Hold payload unless a new word moves in
    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

[sv/xtea_checker.sv]
`timescale 1ns / 1ps

module xtea_checker
    import xtea_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_stall,
    input  logic  out_valid,
    input  logic  out_stall,
    input  word_t out_first_word,
    input  word_t out_second_word
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    // Input backs up only when the output is stalled with a word waiting
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled output word");

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled output word dropped");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(out_first_word) && $stable(out_second_word)))
        else $error("stalled output word changed");

endmodule

bind xtea_block_cipher xtea_checker u_xtea_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_word  (out_first_word),
    .out_second_word (out_second_word)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import xtea_pkg::*;

    // Key register indexes on the configuration port
    localparam key_sel_t REG_KEY_WORD_0 = 2'd0;
    localparam key_sel_t REG_KEY_WORD_1 = 2'd1;
    localparam key_sel_t REG_KEY_WORD_2 = 2'd2;
    localparam key_sel_t REG_KEY_WORD_3 = 2'd3;

    localparam int DRAIN_CYCLES  = 2 * CYCLES + 8;
    localparam int PHASE_BLOCKS  = 96;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Tracks the cipher key, predicts each block and checks the outgoing words
    class block_tracker;
        typedef struct packed
        {
            word_t first;
            word_t second;
        } block_t;

        word_t  key_words [KEY_WORDS];
        block_t expected_blocks [$];
        int     mismatch_count;

        function new();
            foreach (key_words[i])
                key_words[i] = '0;
            mismatch_count = 0;
        endfunction

        function word_t mix_word(input word_t x);
            return ((x << 4) ^ (x >> 5)) + x;
        endfunction

        // Full XTEA transform of one block under the current key
        function block_t xtea_transform(input action_t act, input word_t v0, input word_t v1);
            word_t  s;
            block_t res;
            if (act == ACT_ENCRYPT)
            begin
                s = '0;
                for (int i = 0; i < CYCLES; i++)
                begin
                    v0 += mix_word(v1) ^ (s + key_words[s[1:0]]);
                    s  += DELTA;
                    v1 += mix_word(v0) ^ (s + key_words[s[12:11]]);
                end
            end
            else
            begin
                s = word_t'(DELTA * CYCLES);
                for (int i = 0; i < CYCLES; i++)
                begin
                    v1 -= mix_word(v0) ^ (s + key_words[s[12:11]]);
                    s  -= DELTA;
                    v0 -= mix_word(v1) ^ (s + key_words[s[1:0]]);
                end
            end
            res.first  = v0;
            res.second = v1;
            return res;
        endfunction

        task report(input string msg);
            $display("%0t ns: %s", $time, msg);
            mismatch_count++;
        endtask

        function void note_block(input action_t act, input word_t a, input word_t b);
            expected_blocks.push_back(xtea_transform(act, a, b));
        endfunction

        task check_block(input word_t got_first, input word_t got_second);
            block_t want;
            if (expected_blocks.size() == 0)
            begin
                report($sformatf("unexpected word %08h %08h", got_first, got_second));
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (got_first !== want.first)
                    report($sformatf("out_first_word %08h, predicted %08h",
                                     got_first, want.first));
                if (got_second !== want.second)
                    report($sformatf("out_second_word %08h, predicted %08h",
                                     got_second, want.second));
            end
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_write = 1'b0;
    key_sel_t cfg_index = REG_KEY_WORD_0;
    word_t    cfg_data = '0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    logic     action = ACT_ENCRYPT;
    word_t    first_word = '0;
    word_t    second_word = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    word_t    out_first_word;
    word_t    out_second_word;

    bit           idling_on = 1'b1;
    block_tracker tracker = new();

    xtea_block_cipher i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .first_word      (first_word),
        .second_word     (second_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_first_word  (out_first_word),
        .out_second_word (out_second_word)
    );

    always #2 clk = ~clk;

    // Watch both channels and feed the tracker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_block(action_t'(action), first_word, second_word);
            if (out_valid && !out_stall)
                tracker.check_block(out_first_word, out_second_word);
        end
    end

    // Stall the output side in random bursts, then let it run for a while
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (idling_on && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // Present one word and hold it until the block takes it
    task automatic send_block(input action_t act, input word_t a, input word_t b);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        first_word  <= a;
        second_word <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Write all four key words in back-to-back cycles
    task automatic load_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
        cfg_write <= 1'b1;
        cfg_index <= REG_KEY_WORD_0;
        cfg_data  <= k0;
        @(posedge clk);
        cfg_index <= REG_KEY_WORD_1;
        cfg_data  <= k1;
        @(posedge clk);
        cfg_index <= REG_KEY_WORD_2;
        cfg_data  <= k2;
        @(posedge clk);
        cfg_index <= REG_KEY_WORD_3;
        cfg_data  <= k3;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.key_words[REG_KEY_WORD_0] = k0;
        tracker.key_words[REG_KEY_WORD_1] = k1;
        tracker.key_words[REG_KEY_WORD_2] = k2;
        tracker.key_words[REG_KEY_WORD_3] = k3;
    endtask

    // Drop valid and wait until every predicted block has come out
    task automatic drain_blocks();
        in_valid <= 1'b0;
        while (tracker.expected_blocks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Extreme and patterned halves, each both ways
    task automatic run_directed();
        word_t pat_a [6] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000,
                             32'hffff_ffff, 32'h8000_0000, 32'haaaa_aaaa};
        word_t pat_b [6] = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff,
                             32'h0000_0000, 32'h0000_0001, 32'h5555_5555};
        for (int i = 0; i < 6; i++)
        begin
            send_block(ACT_ENCRYPT, pat_a[i], pat_b[i]);
            send_block(ACT_DECRYPT, pat_a[i], pat_b[i]);
        end
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_block(action_t'($urandom_range(0, 1)), $urandom, $urandom);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key first, then a key with distinct words
        run_directed();
        drain_blocks();
        load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
        run_directed();
        drain_blocks();

        load_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        run_random(PHASE_BLOCKS);
        drain_blocks();

        load_key($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_BLOCKS);
        drain_blocks();

        load_key(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
        run_random(PHASE_BLOCKS);
        drain_blocks();

        load_key($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_BLOCKS);
        drain_blocks();

        load_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        run_random(PHASE_BLOCKS);
        drain_blocks();

        // Full rate on both sides for the last stretch
        idling_on = 1'b0;
        load_key($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_BLOCKS);
        drain_blocks();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("xtea_block_cipher: match");
        else
            $display("xtea_block_cipher: mismatch");
        $finish;
    end

    // Hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("xtea_block_cipher: mismatch");
        $finish;
    end

endmodule

[sim.f]
sv/xtea_pkg.sv
sv/xtea_key_bank.sv
sv/xtea_round.sv
sv/xtea_block_cipher.sv
sv/xtea_checker.sv
verif/tb_top.sv
